/* hw/rtl/srtb_pkg.sv */
// Shared types and constants for the scaled range timer bank.
// Used by the controller, the datapath and the top level; no dependencies.
package srtb_pkg;
  localparam int NUM_TIMERS = 16;
  localparam int ID_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam logic [16:0] SCALE_ONE = 17'd65536;

  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_ENABLE  = 2'd1;
  localparam logic [1:0] ACT_DISABLE = 2'd2;
  localparam logic [1:0] ACT_SCALE   = 2'd3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_SCALE = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic          load;     // capture the accepted item
    logic          apply;    // apply enable/disable/scale
    logic          tick_inc; // advance time
    logic          rd;       // read timer entry scan_id
    logic          eval;     // evaluate the entry read by the preceding rd
    logic [ID_W-1:0] scan_id;
  } srtb_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_tick;
    logic expire;  // evaluated entry expired
  } srtb_sts_t;
endpackage

/* hw/rtl/srtb_datapath.sv */
// Timer storage, time base, scale register and expiry evaluation.
// Depends on srtb_pkg.
module srtb_datapath import srtb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  srtb_cmd_t   cmd,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_timer_id,
  input  logic [23:0] in_min_ms,
  input  logic [23:0] in_max_ms,
  input  logic [16:0] in_scale_value,
  output srtb_sts_t   sts
);
  logic [1:0]  phase_r [NUM_TIMERS];
  logic [31:0] start_mem [NUM_TIMERS];
  logic [23:0] wait_mem [NUM_TIMERS];
  logic [24:0] span_mem [NUM_TIMERS];
  logic [31:0] now_r;
  logic [16:0] scale_r;
  logic [1:0]  act_r;
  logic [3:0]  id_r;
  logic [23:0] min_r, max_r;
  logic [16:0] sv_r;
  logic [31:0] st_q;
  logic [23:0] wt_q;
  logic [24:0] sp_q;
  logic [ID_W-1:0] eid_r;
  logic [1:0]  ph_q;
  logic [31:0] el_wait, el_scale;
  logic        wait_done, to_scale, due, expire;
  logic [41:0] prod;
  logic        id_ok;

  assign id_ok = ({28'd0, id_r} < 32'(NUM_TIMERS));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action; id_r <= in_timer_id; min_r <= in_min_ms;
      max_r <= in_max_ms; sv_r <= in_scale_value;
    end
    if (cmd.rd) begin
      st_q <= start_mem[cmd.scan_id];
      wt_q <= wait_mem[cmd.scan_id];
      sp_q <= span_mem[cmd.scan_id];
      eid_r <= cmd.scan_id;
    end
    if (cmd.apply && act_r == ACT_ENABLE && id_ok) begin
      start_mem[id_r[ID_W-1:0]] <= now_r;
      wait_mem[id_r[ID_W-1:0]] <= min_r;
      span_mem[id_r[ID_W-1:0]] <= (min_r == 24'd0) ? {1'b0, max_r}
                                 : ({1'b0, max_r} - {1'b0, min_r});
    end else if (cmd.eval && to_scale) begin
      start_mem[eid_r] <= now_r;
    end
  end

  // Scaling compare uses the span against elapsed; on a wait exit elapsed is 0.
  assign ph_q = phase_r[eid_r];
  assign el_wait = now_r - st_q;
  assign wait_done = (ph_q == PH_WAIT) && (el_wait >= {8'd0, wt_q});
  assign to_scale = wait_done && !sp_q[24];
  assign el_scale = to_scale ? 32'd0 : el_wait;
  assign prod = {17'd0, sp_q} * {25'd0, scale_r};
  assign due = ({el_scale, 16'd0} >= {6'd0, prod});
  assign expire = (wait_done && sp_q[24]) ||
                  ((ph_q == PH_SCALE || to_scale) && due);
  assign sts.expire = expire;
  assign sts.is_tick = (act_r == ACT_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= 32'd0;
      scale_r <= SCALE_ONE;
      for (int i = 0; i < NUM_TIMERS; i++) phase_r[i] <= PH_IDLE;
    end else begin
      if (cmd.tick_inc) now_r <= now_r + 32'd1;
      if (cmd.apply) begin
        case (act_r)
          ACT_ENABLE: if (id_ok)
            phase_r[id_r[ID_W-1:0]] <= (min_r == 24'd0) ? PH_SCALE : PH_WAIT;
          ACT_DISABLE: if (id_ok) phase_r[id_r[ID_W-1:0]] <= PH_IDLE;
          ACT_SCALE: scale_r <= (sv_r > SCALE_ONE) ? SCALE_ONE : sv_r;
          default: ;
        endcase
      end
      if (cmd.eval) begin
        if (expire) phase_r[eid_r] <= PH_IDLE;
        else if (to_scale) phase_r[eid_r] <= PH_SCALE;
      end
    end
  end
endmodule

/* hw/rtl/srtb_ctrl.sv */
// Sequencer: accepts items, scans timers on a tick and emits results.
// Depends on srtb_pkg.
module srtb_ctrl import srtb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output logic      out_fired,
  output logic [3:0] out_fired_id,
  output logic      out_last,
  output srtb_cmd_t cmd,
  input  srtb_sts_t sts
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_DEC = 5'b00010, S_RD = 5'b00100,
    S_EVAL = 5'b01000, S_OUT = 5'b10000
  } state_t;
  state_t state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;   // next entry to read
  logic [CNT_W-1:0] nout_r, nout_nxt; // results found in this tick
  logic             pend_r, pend_nxt; // a found expiry waits for its last flag
  logic [3:0]       pid_r, pid_nxt;
  logic             ov_r, ov_nxt, of_r, of_nxt, ol_r, ol_nxt;
  logic [3:0]       oid_r, oid_nxt;
  logic             done_scan;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_fired = of_r;
  assign out_fired_id = oid_r;
  assign out_last = ol_r;
  assign done_scan = (idx_r == CNT_W'(NUM_TIMERS)) || (nout_r == CNT_W'(16));

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; nout_nxt = nout_r;
    pend_nxt = pend_r; pid_nxt = pid_r;
    ov_nxt = ov_r && !out_ready; of_nxt = of_r; oid_nxt = oid_r; ol_nxt = ol_r;
    cmd = '0;
    cmd.scan_id = idx_r[ID_W-1:0];
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1; state_nxt = S_DEC;
      end
      S_DEC: if (!ov_nxt) begin
        if (sts.is_tick) begin
          cmd.tick_inc = 1'b1; idx_nxt = '0; nout_nxt = '0; pend_nxt = 1'b0;
          state_nxt = S_RD;
        end else begin
          cmd.apply = 1'b1;
          ov_nxt = 1'b1; of_nxt = 1'b0; oid_nxt = 4'd0; ol_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RD: if (done_scan) begin
        state_nxt = S_OUT;
      end else begin
        cmd.rd = 1'b1; idx_nxt = idx_r + CNT_W'(1); state_nxt = S_EVAL;
      end
      S_EVAL: if (!(pend_r && sts.expire && ov_nxt)) begin
        // A found expiry is held until the next one or the end of the scan so the last flag can be set on it.
        cmd.eval = 1'b1;
        if (sts.expire) begin
          if (pend_r) begin
            ov_nxt = 1'b1; of_nxt = 1'b1; oid_nxt = pid_r; ol_nxt = 1'b0;
          end
          pend_nxt = 1'b1;
          pid_nxt = 4'(idx_r - CNT_W'(1));
          nout_nxt = nout_r + CNT_W'(1);
        end
        state_nxt = S_RD;
      end
      S_OUT: if (!ov_nxt) begin
        ov_nxt = 1'b1; ol_nxt = 1'b1;
        of_nxt = pend_r; oid_nxt = pend_r ? pid_r : 4'd0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; idx_r <= '0; nout_r <= '0; pend_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; idx_r <= idx_nxt; nout_r <= nout_nxt;
      pend_r <= pend_nxt; ov_r <= ov_nxt;
    end
    pid_r <= pid_nxt; of_r <= of_nxt; oid_r <= oid_nxt; ol_r <= ol_nxt;
  end
endmodule

/* hw/rtl/scaled_range_timer_bank.sv */
// Top level of the scaled range timer bank: controller plus datapath.
// Depends on srtb_pkg, srtb_ctrl and srtb_datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    action, timer_id, min_ms, max_ms, scale_value
//   out      output     out_valid / out_ready  fired, fired_id, last
//
// An enable, disable or scale item is accepted, then decoded and applied. A tick is
// accepted and decoded, then the scan reads one timer entry in S_RD and evaluates it in
// S_EVAL before the next read, over a single storage read port; after the end of scan
// the final result is sent.
// Reset clears the time base, all timer phases and sets the scale to 1.0.
// A stalled result transfer holds the scan until the output register frees.
module scaled_range_timer_bank import srtb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_timer_id,
  input  logic [23:0] in_min_ms,
  input  logic [23:0] in_max_ms,
  input  logic [16:0] in_scale_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_fired,
  output logic [3:0]  out_fired_id,
  output logic        out_last
);
  srtb_cmd_t cmd;
  srtb_sts_t sts;

  // The controller sequences the scan; the datapath holds all timer state.
  srtb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .out_fired, .out_fired_id, .out_last, .cmd, .sts
  );

  srtb_datapath u_dp (
    .clk, .rst_n, .cmd, .in_action, .in_timer_id, .in_min_ms, .in_max_ms,
    .in_scale_value, .sts
  );

  // An acknowledgement never reports a timer.
  a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fired) |-> (out_last && out_fired_id == 4'd0))
    else $error("acknowledgement carries a timer id");

  // No new item is taken while a tick scan is in progress.
  a_no_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd || cmd.eval) |-> !in_ready)
    else $error("input ready during scan");

  // Storage is never updated by an item and a scan in the same cycle.
  a_apply_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.apply && (cmd.eval || cmd.tick_inc)))
    else $error("apply overlaps scan");
endmodule
